### rtl/bdq_pkg.sv
// Shared types and constants of the bounded array deque.
// Holds the request decode, the command record between front and back, and the
// engine state encoding. No dependencies.
package bdq_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CNT_W    = 8;

  // Value reported for front and back while the deque is empty.
  localparam logic [DATA_W-1:0] EMPTY_READ = '1;

  // Request codes as they arrive on the request channel.
  typedef enum logic [REQ_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_REVERSE    = 3'd5,
    OP_SORT       = 3'd6,
    OP_STATUS     = 3'd7
  } bdq_op_e;

  // Outcome codes reported with every result.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } bdq_status_e;

  // Classified command handed from the front to the engine.
  typedef struct packed {
    bdq_op_e                  op;
    logic                     is_push;
    logic                     is_pop;
    logic                     from_back;
    logic signed [DATA_W-1:0] value;
  } bdq_cmd_t;

  // Engine sequencer states.
  typedef enum logic [3:0] {
    ES_IDLE,
    ES_POP_CAP,
    ES_REV_RD_J,
    ES_REV_WR_I,
    ES_REV_WR_J,
    ES_SORT_KEY,
    ES_SORT_CMP,
    ES_SORT_PLACE,
    ES_FIX_H,
    ES_FIX_F,
    ES_FIX_B,
    ES_RESULT
  } bdq_state_e;

endpackage

### rtl/bdq_if.sv
// Valid/ready channel interfaces of the bounded array deque.
// Depends on bdq_pkg for the field widths.

// Request channel: one request type and one push value per transfer.
interface bdq_req_if;
  logic                              valid;
  logic                              ready;
  logic [bdq_pkg::REQ_W-1:0]         req_type;
  logic signed [bdq_pkg::DATA_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

// Result channel: one result per request.
interface bdq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [bdq_pkg::STATUS_W-1:0]      status;
  logic signed [bdq_pkg::DATA_W-1:0] popped_value;
  logic signed [bdq_pkg::DATA_W-1:0] front_value;
  logic signed [bdq_pkg::DATA_W-1:0] back_value;
  logic [bdq_pkg::CNT_W-1:0]         count;
  logic                              is_empty;

  modport source (output valid, output status, output popped_value, output front_value,
                  output back_value, output count, output is_empty, input ready);
  modport sink   (input valid, input status, input popped_value, input front_value,
                  input back_value, input count, input is_empty, output ready);
endinterface

### rtl/bdq_front.sv
// Request front end: accepts request transfers and classifies them into commands.
// Depends on bdq_pkg and bdq_req_if.
module bdq_front (
  bdq_req_if.sink           req_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output bdq_pkg::bdq_cmd_t cmd_o
);

  bdq_pkg::bdq_op_e op;

  // A request is taken whenever the command queue has room.
  assign req_i.ready = cmd_ready_i;
  assign cmd_valid_o = req_i.valid;
  assign op          = bdq_pkg::bdq_op_e'(req_i.req_type);

  // Classify the request by end and by kind of access.
  always_comb begin
    cmd_o.op        = op;
    cmd_o.value     = req_i.value;
    cmd_o.is_push   = op inside {bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK};
    cmd_o.is_pop    = op inside {bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK};
    cmd_o.from_back = op inside {bdq_pkg::OP_PUSH_BACK, bdq_pkg::OP_POP_BACK};
  end

endmodule

### rtl/bdq_cmd_queue.sv
// Two-entry command queue between the request front end and the engine.
// Depends on bdq_pkg for the command record.
module bdq_cmd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  bdq_pkg::bdq_cmd_t push_cmd_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output bdq_pkg::bdq_cmd_t pop_cmd_o
);

  localparam int unsigned Entries = 2;

  bdq_pkg::bdq_cmd_t entry_q [Entries];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        fill_q, fill_d;
  logic              push, pop;

  assign push_ready_o = (fill_q != 2'(Entries));
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### rtl/bdq_engine.sv
// Deque engine: slot memory, run bounds, reverse and sort sequencer, result register.
// Depends on bdq_pkg and bdq_rsp_if.
module bdq_engine #(
  parameter int unsigned DEPTH = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  bdq_pkg::bdq_cmd_t cmd_i,
  bdq_rsp_if.source         rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  typedef logic [bdq_pkg::DATA_W-1:0] word_t;

  bdq_pkg::bdq_state_e  state_q, state_d;
  logic [AW-1:0]        head_q, head_d, tail_q, tail_d;
  logic                 empty_q, empty_d;
  word_t                front_q, front_d, back_q, back_d;
  logic [AW-1:0]        i_q, i_d, j_q, j_d;
  word_t                key_q, key_d, tmp_q, tmp_d;
  logic                 from_back_q, from_back_d;
  bdq_pkg::bdq_status_e status_q, status_d;
  word_t                popped_q, popped_d;

  // Slot memory: one write and one registered read per cycle.
  word_t                mem_q [DEPTH];
  word_t                rd_data_q;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  word_t                mem_wdata;

  logic                 rsp_valid_q, rsp_valid_d;
  logic                 out_free, load_rsp, multi;
  logic [15:0]          cnt_wide;

  assign multi    = !empty_q && (head_q != tail_q);
  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign cnt_wide = 16'(tail_q) - 16'(head_q) + 16'd1;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bdq_pkg::ES_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.is_pop && multi) begin
            state_d = bdq_pkg::ES_POP_CAP;
          end else if (cmd_i.op == bdq_pkg::OP_REVERSE && multi) begin
            state_d = bdq_pkg::ES_REV_RD_J;
          end else if (cmd_i.op == bdq_pkg::OP_SORT && multi) begin
            state_d = bdq_pkg::ES_SORT_KEY;
          end else begin
            state_d = bdq_pkg::ES_RESULT;
          end
        end
      end
      bdq_pkg::ES_POP_CAP:  state_d = bdq_pkg::ES_RESULT;
      bdq_pkg::ES_REV_RD_J: state_d = bdq_pkg::ES_REV_WR_I;
      bdq_pkg::ES_REV_WR_I: state_d = bdq_pkg::ES_REV_WR_J;
      bdq_pkg::ES_REV_WR_J: begin
        if (({1'b0, i_q} + (AW+1)'(2)) < {1'b0, j_q}) begin
          state_d = bdq_pkg::ES_REV_RD_J;
        end else begin
          state_d = bdq_pkg::ES_RESULT;
        end
      end
      bdq_pkg::ES_SORT_KEY: state_d = bdq_pkg::ES_SORT_CMP;
      bdq_pkg::ES_SORT_CMP: begin
        if (!($signed(rd_data_q) > $signed(key_q)) ||
            ({1'b0, j_q} <= ({1'b0, head_q} + (AW+1)'(1)))) begin
          state_d = bdq_pkg::ES_SORT_PLACE;
        end
      end
      bdq_pkg::ES_SORT_PLACE: begin
        state_d = (i_q == tail_q) ? bdq_pkg::ES_FIX_H : bdq_pkg::ES_SORT_KEY;
      end
      bdq_pkg::ES_FIX_H: state_d = bdq_pkg::ES_FIX_F;
      bdq_pkg::ES_FIX_F: state_d = bdq_pkg::ES_FIX_B;
      bdq_pkg::ES_FIX_B: state_d = bdq_pkg::ES_RESULT;
      bdq_pkg::ES_RESULT: begin
        if (out_free) begin
          state_d = bdq_pkg::ES_IDLE;
        end
      end
      default: state_d = bdq_pkg::ES_IDLE;
    endcase
  end

  // Datapath and memory control of each state.
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    empty_d     = empty_q;
    front_d     = front_q;
    back_d      = back_q;
    i_d         = i_q;
    j_d         = j_q;
    key_d       = key_q;
    tmp_d       = tmp_q;
    from_back_d = from_back_q;
    status_d    = status_q;
    popped_d    = popped_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    cmd_ready_o = 1'b0;
    load_rsp    = 1'b0;

    case (state_q)
      bdq_pkg::ES_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          from_back_d = cmd_i.from_back;
          status_d    = bdq_pkg::ST_OK;
          popped_d    = '0;
          if (cmd_i.is_push) begin
            if (empty_q) begin
              // A push into an empty deque starts a new run at slot zero.
              head_d    = '0;
              tail_d    = '0;
              empty_d   = 1'b0;
              front_d   = cmd_i.value;
              back_d    = cmd_i.value;
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = cmd_i.value;
            end else if (cmd_i.from_back) begin
              if (tail_q == LastIdx) begin
                status_d = bdq_pkg::ST_OVERFLOW;
              end else begin
                tail_d    = tail_q + AW'(1);
                back_d    = cmd_i.value;
                mem_we    = 1'b1;
                mem_waddr = tail_q + AW'(1);
                mem_wdata = cmd_i.value;
              end
            end else begin
              if (head_q == '0) begin
                status_d = bdq_pkg::ST_OVERFLOW;
              end else begin
                head_d    = head_q - AW'(1);
                front_d   = cmd_i.value;
                mem_we    = 1'b1;
                mem_waddr = head_q - AW'(1);
                mem_wdata = cmd_i.value;
              end
            end
          end else if (cmd_i.is_pop) begin
            if (empty_q) begin
              status_d = bdq_pkg::ST_UNDERFLOW;
            end else begin
              popped_d = cmd_i.from_back ? back_q : front_q;
              if (head_q == tail_q) begin
                head_d  = '0;
                tail_d  = '0;
                empty_d = 1'b1;
              end else if (cmd_i.from_back) begin
                // Fetch the new back element.
                tail_d    = tail_q - AW'(1);
                mem_re    = 1'b1;
                mem_raddr = tail_q - AW'(1);
              end else begin
                // Fetch the new front element.
                head_d    = head_q + AW'(1);
                mem_re    = 1'b1;
                mem_raddr = head_q + AW'(1);
              end
            end
          end else if (cmd_i.op == bdq_pkg::OP_CLEAR) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b1;
          end else if (cmd_i.op == bdq_pkg::OP_REVERSE && multi) begin
            // The ends trade places; the swap walk runs from both ends inward.
            i_d       = head_q;
            j_d       = tail_q;
            front_d   = back_q;
            back_d    = front_q;
            mem_re    = 1'b1;
            mem_raddr = head_q;
          end else if (cmd_i.op == bdq_pkg::OP_SORT && multi) begin
            // Insertion sort starts with the second element as key.
            i_d       = head_q + AW'(1);
            j_d       = head_q + AW'(1);
            mem_re    = 1'b1;
            mem_raddr = head_q + AW'(1);
          end
        end
      end

      bdq_pkg::ES_POP_CAP: begin
        if (from_back_q) begin
          back_d = rd_data_q;
        end else begin
          front_d = rd_data_q;
        end
      end

      bdq_pkg::ES_REV_RD_J: begin
        tmp_d     = rd_data_q;
        mem_re    = 1'b1;
        mem_raddr = j_q;
      end

      bdq_pkg::ES_REV_WR_I: begin
        mem_we    = 1'b1;
        mem_waddr = i_q;
        mem_wdata = rd_data_q;
      end

      bdq_pkg::ES_REV_WR_J: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = tmp_q;
        i_d       = i_q + AW'(1);
        j_d       = j_q - AW'(1);
        // Start reading the next pair while the current one retires.
        if (({1'b0, i_q} + (AW+1)'(2)) < {1'b0, j_q}) begin
          mem_re    = 1'b1;
          mem_raddr = i_q + AW'(1);
        end
      end

      bdq_pkg::ES_SORT_KEY: begin
        key_d     = rd_data_q;
        mem_re    = 1'b1;
        mem_raddr = j_q - AW'(1);
      end

      bdq_pkg::ES_SORT_CMP: begin
        // Shift a larger neighbor up by one slot and look one further down.
        if ($signed(rd_data_q) > $signed(key_q)) begin
          mem_we    = 1'b1;
          mem_waddr = j_q;
          mem_wdata = rd_data_q;
          j_d       = j_q - AW'(1);
          if ({1'b0, j_q} > ({1'b0, head_q} + (AW+1)'(1))) begin
            mem_re    = 1'b1;
            mem_raddr = j_q - AW'(2);
          end
        end
      end

      bdq_pkg::ES_SORT_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = key_q;
        if (i_q != tail_q) begin
          i_d       = i_q + AW'(1);
          j_d       = i_q + AW'(1);
          mem_re    = 1'b1;
          mem_raddr = i_q + AW'(1);
        end
      end

      // Reload the cached end values after a sort.
      bdq_pkg::ES_FIX_H: begin
        mem_re    = 1'b1;
        mem_raddr = head_q;
      end

      bdq_pkg::ES_FIX_F: begin
        front_d   = rd_data_q;
        mem_re    = 1'b1;
        mem_raddr = tail_q;
      end

      bdq_pkg::ES_FIX_B: begin
        back_d = rd_data_q;
      end

      bdq_pkg::ES_RESULT: begin
        load_rsp = out_free;
      end

      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdq_pkg::ES_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
    end
  end

  // Working registers that need no reset.
  always_ff @(posedge clk_i) begin
    front_q     <= front_d;
    back_q      <= back_d;
    i_q         <= i_d;
    j_q         <= j_d;
    key_q       <= key_d;
    tmp_q       <= tmp_d;
    from_back_q <= from_back_d;
    status_q    <= status_d;
    popped_q    <= popped_d;
  end

  // Slot memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  // Result register on the output channel.
  always_comb begin
    if (load_rsp) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_rsp) begin
      rsp_o.status       <= status_q;
      rsp_o.popped_value <= popped_q;
      rsp_o.front_value  <= empty_q ? bdq_pkg::EMPTY_READ : front_q;
      rsp_o.back_value   <= empty_q ? bdq_pkg::EMPTY_READ : back_q;
      rsp_o.count        <= empty_q ? '0 : cnt_wide[bdq_pkg::CNT_W-1:0];
      rsp_o.is_empty     <= empty_q;
    end
  end

  assign rsp_o.valid = rsp_valid_q;

endmodule

### rtl/bounded_array_deque_core.sv
// Top level of the bounded array deque: front end, command queue and engine.
// Depends on bdq_pkg, bdq_if, bdq_front, bdq_cmd_queue and bdq_engine.
//
//   Channel  Port   Direction  Carries
//   request  req_i  in         req_type, value
//   result   rsp_o  out        status, popped_value, front_value, back_value,
//                              count, is_empty
//
// Push, clear, status and trivial reverse or sort go straight to the result state;
// a pop that leaves elements first captures the new end from the slot memory.
// Reverse swaps pairs from both ends inward; sort steps through key, compare and
// place per element, comparing again for each shifted element, and then reloads
// both ends, all bound by the one read and one write port of the slot memory.
// Reset clears the run bounds and sets the empty flag at once; slots are not cleared.
// Up to two requests queue in front of the engine while it works or while a
// result waits in the output register.
module bounded_array_deque_core #(
  parameter int unsigned DEPTH = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bdq_req_if.sink   req_i,
  bdq_rsp_if.source rsp_o
);

  logic              front_valid, front_ready;
  bdq_pkg::bdq_cmd_t front_cmd;
  logic              eng_valid, eng_ready;
  bdq_pkg::bdq_cmd_t eng_cmd;

  // Accept and classify requests.
  bdq_front u_front (
    .req_i       (req_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  // Decouple the front end from the engine.
  bdq_cmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (eng_valid),
    .pop_ready_i  (eng_ready),
    .pop_cmd_o    (eng_cmd)
  );

  // Carry out commands against the slot memory.
  bdq_engine #(
    .DEPTH (DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (eng_valid),
    .cmd_ready_o (eng_ready),
    .cmd_i       (eng_cmd),
    .rsp_o       (rsp_o)
  );

`ifndef NO_ASSERTIONS
  // An empty deque reports no elements and the empty marker at both ends.
  a_empty_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.is_empty |->
      rsp_o.count == '0 && rsp_o.front_value == -32'sd1 && rsp_o.back_value == -32'sd1)
    else $error("empty result with elements or end values");

  // A failed request never reports a popped value.
  a_fail_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != bdq_pkg::ST_OK |-> rsp_o.popped_value == '0)
    else $error("failed request with popped value");

  // Overflow only happens on a deque that holds elements.
  a_overflow_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == bdq_pkg::ST_OVERFLOW |-> !rsp_o.is_empty)
    else $error("overflow reported on empty deque");

  // Underflow leaves the deque empty.
  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == bdq_pkg::ST_UNDERFLOW |-> rsp_o.is_empty)
    else $error("underflow reported on non-empty deque");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for bounded_array_deque_core.
// It predicts every result of the deque from a shadow copy of the slot array.
// Depends on bdq_pkg, the bdq_if interfaces and the deque RTL.
module tb_top;

  localparam int unsigned DEPTH        = 128;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned LIMIT_CYCLES = 20000000;
  localparam int unsigned DRAIN_CYCLES = 40;

  // One predicted result of the deque.
  typedef struct {
    bdq_pkg::bdq_status_e status;
    logic signed [31:0]   popped;
    logic signed [31:0]   front;
    logic signed [31:0]   back;
    logic [7:0]           count;
    logic                 is_empty;
  } deque_result_t;

  logic clk_i;
  logic rst_ni;

  bdq_req_if req_bus ();
  bdq_rsp_if rsp_bus ();

  bounded_array_deque_core #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  // Shadow state of the deque.
  logic signed [31:0] shadow_slots [DEPTH];
  int                 shadow_head;
  int                 shadow_tail;
  bit                 shadow_empty;

  deque_result_t pending_results [$];
  deque_result_t oldest_result;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_req_cnt;
  int unsigned hold_seen_cnt;
  int unsigned hold_left;
  int unsigned cycle_cnt;
  int unsigned error_count;
  int unsigned results_checked;
  int unsigned requests_sent;
  int unsigned overflow_cnt;
  int unsigned underflow_cnt;
  int unsigned sort_cnt;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Applies one request to the shadow deque and returns the result it causes.
  function automatic deque_result_t deque_apply(bdq_pkg::bdq_op_e op, logic signed [31:0] v);
    deque_result_t      r;
    int                 i;
    int                 j;
    logic signed [31:0] key;
    r.status = bdq_pkg::ST_OK;
    r.popped = '0;
    case (op)
      bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
        if (shadow_empty) begin
          shadow_head     = 0;
          shadow_tail     = 0;
          shadow_empty    = 1'b0;
          shadow_slots[0] = v;
        end else if (op == bdq_pkg::OP_PUSH_FRONT && shadow_head == 0) begin
          r.status = bdq_pkg::ST_OVERFLOW;
        end else if (op == bdq_pkg::OP_PUSH_BACK && shadow_tail == DEPTH - 1) begin
          r.status = bdq_pkg::ST_OVERFLOW;
        end else if (op == bdq_pkg::OP_PUSH_FRONT) begin
          shadow_head--;
          shadow_slots[shadow_head] = v;
        end else begin
          shadow_tail++;
          shadow_slots[shadow_tail] = v;
        end
      end
      bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK: begin
        if (shadow_empty) begin
          r.status = bdq_pkg::ST_UNDERFLOW;
        end else begin
          r.popped = (op == bdq_pkg::OP_POP_FRONT) ? shadow_slots[shadow_head]
                                                   : shadow_slots[shadow_tail];
          if (shadow_head == shadow_tail) begin
            shadow_head  = 0;
            shadow_tail  = 0;
            shadow_empty = 1'b1;
          end else if (op == bdq_pkg::OP_POP_FRONT) begin
            shadow_head++;
          end else begin
            shadow_tail--;
          end
        end
      end
      bdq_pkg::OP_CLEAR: begin
        shadow_head  = 0;
        shadow_tail  = 0;
        shadow_empty = 1'b1;
      end
      bdq_pkg::OP_REVERSE: begin
        if (!shadow_empty) begin
          i = shadow_head;
          j = shadow_tail;
          while (i < j) begin
            key             = shadow_slots[i];
            shadow_slots[i] = shadow_slots[j];
            shadow_slots[j] = key;
            i++;
            j--;
          end
        end
      end
      bdq_pkg::OP_SORT: begin
        // Insertion sort, ascending by signed compare.
        if (!shadow_empty) begin
          for (i = shadow_head + 1; i <= shadow_tail; i++) begin
            key = shadow_slots[i];
            j   = i;
            while (j > shadow_head && shadow_slots[j-1] > key) begin
              shadow_slots[j] = shadow_slots[j-1];
              j--;
            end
            shadow_slots[j] = key;
          end
        end
      end
      default: begin
      end
    endcase
    r.front    = shadow_empty ? bdq_pkg::EMPTY_READ : shadow_slots[shadow_head];
    r.back     = shadow_empty ? bdq_pkg::EMPTY_READ : shadow_slots[shadow_tail];
    r.count    = shadow_empty ? 8'd0 : 8'(shadow_tail - shadow_head + 1);
    r.is_empty = shadow_empty;
    if (r.status == bdq_pkg::ST_OVERFLOW) overflow_cnt++;
    if (r.status == bdq_pkg::ST_UNDERFLOW) underflow_cnt++;
    if (op == bdq_pkg::OP_SORT) sort_cnt++;
    return r;
  endfunction

  // Offers one request and waits for its transfer; the predicted result is queued then.
  task automatic send_req(bdq_pkg::bdq_op_e op, logic signed [31:0] v);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= op;
    req_bus.value    <= v;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    pending_results.insert(pending_results.size(), deque_apply(op, v));
    requests_sent++;
  endtask

  // Stops offering and waits until every predicted result has arrived.
  task automatic wait_results_drained();
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Mostly ordinary random values, with extremes and small values that repeat.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2, 3: return $signed(32'($urandom_range(15))) - 32'sd8;
      default: return $urandom();
    endcase
  endfunction

  // Growing phases favor pushes at the back; shrinking phases favor pops.
  function automatic bdq_pkg::bdq_op_e pick_op(bit growing);
    int unsigned roll;
    roll = $urandom_range(99);
    if (growing) begin
      if (roll < 15) return bdq_pkg::OP_PUSH_FRONT;
      if (roll < 57) return bdq_pkg::OP_PUSH_BACK;
      if (roll < 70) return bdq_pkg::OP_POP_FRONT;
      if (roll < 78) return bdq_pkg::OP_POP_BACK;
      if (roll < 80) return bdq_pkg::OP_CLEAR;
      if (roll < 85) return bdq_pkg::OP_REVERSE;
      if (roll < 88) return bdq_pkg::OP_SORT;
      return bdq_pkg::OP_STATUS;
    end
    if (roll < 10) return bdq_pkg::OP_PUSH_FRONT;
    if (roll < 25) return bdq_pkg::OP_PUSH_BACK;
    if (roll < 60) return bdq_pkg::OP_POP_FRONT;
    if (roll < 85) return bdq_pkg::OP_POP_BACK;
    if (roll < 86) return bdq_pkg::OP_CLEAR;
    if (roll < 90) return bdq_pkg::OP_REVERSE;
    if (roll < 93) return bdq_pkg::OP_SORT;
    return bdq_pkg::OP_STATUS;
  endfunction

  // Compares one field of a result and reports a mismatch.
  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Result checker: each transfer on the result channel against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual status %0d count %0d",
                 $time, rsp_bus.status, rsp_bus.count);
      end else begin
        oldest_result = pending_results[0];
        pending_results.delete(0);
        results_checked++;
        compare_field("status", 32'(oldest_result.status), 32'(rsp_bus.status));
        compare_field("popped_value", oldest_result.popped, rsp_bus.popped_value);
        compare_field("front_value", oldest_result.front, rsp_bus.front_value);
        compare_field("back_value", oldest_result.back, rsp_bus.back_value);
        compare_field("count", 32'(oldest_result.count), 32'(rsp_bus.count));
        compare_field("is_empty", 32'(oldest_result.is_empty), 32'(rsp_bus.is_empty));
      end
    end
  end

  // Result ready: random stalls, plus a long hold-off whenever a test asks for one.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else if (hold_seen_cnt != hold_req_cnt) begin
      hold_seen_cnt <= hold_req_cnt;
      hold_left     <= HOLD_CYCLES;
      rsp_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_cnt, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Requests on an empty deque, including underflow on both ends.
  task automatic test_empty_requests();
    send_req(bdq_pkg::OP_STATUS, 32'sd0);
    send_req(bdq_pkg::OP_POP_FRONT, 32'sd0);
    send_req(bdq_pkg::OP_POP_BACK, 32'sd0);
    send_req(bdq_pkg::OP_REVERSE, 32'sd0);
    send_req(bdq_pkg::OP_SORT, 32'sd0);
    send_req(bdq_pkg::OP_CLEAR, 32'sd0);
  endtask

  // A run of one element: trivial reverse and sort, front overflow at slot zero.
  task automatic test_single_element();
    send_req(bdq_pkg::OP_PUSH_FRONT, 32'sh80000000);
    send_req(bdq_pkg::OP_REVERSE, 32'sd0);
    send_req(bdq_pkg::OP_SORT, 32'sd0);
    send_req(bdq_pkg::OP_PUSH_FRONT, 32'sd1);
    send_req(bdq_pkg::OP_POP_BACK, 32'sd0);
  endtask

  // Extreme values and alternating bit patterns through every operation.
  task automatic test_run_edges();
    send_req(bdq_pkg::OP_PUSH_BACK, 32'sh7FFFFFFF);
    send_req(bdq_pkg::OP_PUSH_BACK, 32'shAAAAAAAA);
    send_req(bdq_pkg::OP_PUSH_BACK, 32'sh55555555);
    send_req(bdq_pkg::OP_PUSH_BACK, -32'sd1);
    send_req(bdq_pkg::OP_PUSH_BACK, 32'sd0);
    send_req(bdq_pkg::OP_POP_FRONT, 32'sd0);
    send_req(bdq_pkg::OP_PUSH_FRONT, 32'shFFFFFFFE);
    send_req(bdq_pkg::OP_REVERSE, 32'sd0);
    send_req(bdq_pkg::OP_SORT, 32'sd0);
    send_req(bdq_pkg::OP_POP_FRONT, 32'sd0);
    send_req(bdq_pkg::OP_POP_BACK, 32'sd0);
    send_req(bdq_pkg::OP_CLEAR, 32'sd0);
    send_req(bdq_pkg::OP_STATUS, 32'sd0);
  endtask

  // Fills every slot while results are held off, so the input stalls; then
  // overflows both ends and reorders the full array.
  task automatic test_fill_to_capacity();
    int k;
    hold_req_cnt++;
    send_req(bdq_pkg::OP_CLEAR, 32'sd0);
    for (k = 0; k < DEPTH; k++) send_req(bdq_pkg::OP_PUSH_BACK, pick_value());
    send_req(bdq_pkg::OP_PUSH_BACK, pick_value());
    send_req(bdq_pkg::OP_PUSH_FRONT, pick_value());
    send_req(bdq_pkg::OP_SORT, 32'sd0);
    send_req(bdq_pkg::OP_REVERSE, 32'sd0);
    for (k = 0; k < 3; k++) send_req(bdq_pkg::OP_POP_FRONT, 32'sd0);
    for (k = 0; k < 4; k++) send_req(bdq_pkg::OP_PUSH_FRONT, pick_value());
    send_req(bdq_pkg::OP_STATUS, 32'sd0);
  endtask

  // The sender pauses until the result channel has caught up.
  task automatic test_sender_pause();
    wait_results_drained();
  endtask

  // Random traffic that alternates between growing and shrinking stretches.
  task automatic test_random_traffic(int n_items);
    int  k;
    int  stretch;
    bit  growing;
    growing = 1'b1;
    stretch = $urandom_range(100, 400);
    for (k = 0; k < n_items; k++) begin
      if (stretch == 0) begin
        growing = !growing;
        stretch = growing ? $urandom_range(100, 400) : $urandom_range(40, 200);
      end
      stretch--;
      send_req(pick_op(growing), pick_value());
    end
  endtask

  // Test sequence.
  initial begin
    rst_ni           <= 1'b0;
    req_bus.valid    <= 1'b0;
    req_bus.req_type <= bdq_pkg::OP_STATUS;
    req_bus.value    <= '0;
    shadow_head      = 0;
    shadow_tail      = 0;
    shadow_empty     = 1'b1;
    hold_req_cnt     = 0;
    error_count      = 0;
    results_checked  = 0;
    requests_sent    = 0;
    overflow_cnt     = 0;
    underflow_cnt    = 0;
    sort_cnt         = 0;
    send_idle_pct    = 11;
    recv_idle_pct    = 53;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_requests();
    test_single_element();
    test_run_edges();
    test_fill_to_capacity();
    test_sender_pause();
    test_random_traffic(600);

    send_idle_pct = 53;
    recv_idle_pct = 11;
    test_random_traffic(600);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(600);

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d requests and checked %0d results over %0d cycles.",
             requests_sent, results_checked, cycle_cnt);
    $display("Seen %0d overflows, %0d underflows and %0d sorts.",
             overflow_cnt, underflow_cnt, sort_cnt);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
